[hdl/rrst_pkg.sv]
package rrst_pkg;

    localparam int ARRIVAL_W = 16;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int TICK_W    = 24;
    localparam int PNUM_W    = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef logic [ARRIVAL_W-1:0] arrival_t;
    typedef logic [BURST_W-1:0]   burst_t;
    typedef logic [QUANTUM_W-1:0] quantum_t;
    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [PNUM_W-1:0]    pnum_t;

    localparam quantum_t QUANTUM_RESET = 16'd4;

    // Register index as decoded from paddr[2].
    localparam logic REG_QUANTUM = 1'b0;

endpackage

[hdl/rrst_in_if.sv]
interface rrst_in_if
    import rrst_pkg::*;
();
    logic     valid;
    logic     ready;
    arrival_t arrival;
    burst_t   burst;
    logic     last_process;

    modport source (
        output valid,
        output arrival,
        output burst,
        output last_process,
        input  ready
    );

    modport sink (
        input  valid,
        input  arrival,
        input  burst,
        input  last_process,
        output ready
    );
endinterface

[hdl/rrst_out_if.sv]
interface rrst_out_if
    import rrst_pkg::*;
();
    logic  valid;
    logic  ready;
    pnum_t process_number;
    tick_t completion;
    tick_t turnaround;
    tick_t waiting;
    logic  last_result;

    modport source (
        output valid,
        output process_number,
        output completion,
        output turnaround,
        output waiting,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  process_number,
        input  completion,
        input  turnaround,
        input  waiting,
        input  last_result,
        output ready
    );
endinterface

[hdl/round_robin_schedule_times_top.sv]
// Round-robin schedule calculator. Processes are loaded one word per cycle on the load channel,
// each with an arrival and a burst time; the word with last_process set starts the schedule
// with the quantum held in the quantum register (address 0, a value of zero acts as one).
// While the schedule runs the load channel is not ready. Each time slice passes through the
// POST, POP, CUR, RUN and UPD states and then a walk over all n loaded processes in the arrival
// memory (ADMIT), and a jump over idle time adds another such walk (FIND); the single read port
// of the arrival and burst memory, which every walk goes through, sets the run time of a batch.
// Results then leave in load order, one at a time: the next is read only once the result
// register is free or being taken by the sink.
// Queue membership is kept in flip-flops, so no clearing pass follows reset.
module round_robin_schedule_times_top
    import rrst_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    rrst_in_if.sink           load,
    rrst_out_if.source        result
);

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int AB_W = ARRIVAL_W + BURST_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCESSES);
    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_PROCESSES - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADMIT = 4'd1;
    localparam logic [3:0] S_POST  = 4'd2;
    localparam logic [3:0] S_FIND  = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_CUR   = 4'd5;
    localparam logic [3:0] S_RUN   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OLD   = 4'd9;

    logic [3:0]               state_reg, state_next;
    quantum_t                 tq_reg;
    logic [CW-1:0]            loaded_reg, loaded_next;
    logic [CW-1:0]            finished_reg, finished_next;
    logic [CW-1:0]            occ_reg, occ_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    tick_t                    tick_reg, tick_next;
    logic [MAX_PROCESSES-1:0] flag_reg, flag_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic                     found_reg, found_next;
    logic                     rem_zero_reg, rem_zero_next;
    logic                     slice_reg, slice_next;
    logic [CW-1:0]            out_idx_reg, out_idx_next;
    logic                     out_vld_reg, out_vld_next;

    logic [IW-1:0]            cmp_idx_reg, cmp_idx_next;
    arrival_t                 best_arr_reg, best_arr_next;
    logic [IW-1:0]            best_idx_reg, best_idx_next;
    logic [IW-1:0]            cur_reg, cur_next;
    burst_t                   run_reg, run_next;
    burst_t                   rem_val_reg, rem_val_next;
    pnum_t                    pnum_reg;
    tick_t                    comp_out_reg;
    tick_t                    tat_out_reg;
    tick_t                    wait_out_reg;
    logic                     last_out_reg;

    logic                     cfg_we;
    quantum_t                 q_eff;
    burst_t                   burst_fix;
    logic                     scan_issue;
    logic                     push_en;
    logic [IW-1:0]            push_idx;
    logic [CW-1:0]            fin_after;
    logic [CW-1:0]            occ_after;
    logic [CW-1:0]            out_idx_inc;
    logic                     out_load;
    tick_t                    tat_calc;

    logic                     ab_we, ab_re;
    logic [IW-1:0]            ab_raddr;
    logic [AB_W-1:0]          ab_rdata;
    arrival_t                 arr_rd;
    burst_t                   bur_rd;
    logic                     rem_we, rem_re;
    logic [IW-1:0]            rem_waddr;
    burst_t                   rem_wdata;
    burst_t                   rem_rdata;
    logic                     q_re;
    logic [IW-1:0]            q_rdata;
    logic                     comp_we, comp_re;
    tick_t                    comp_rdata;

    assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_QUANTUM);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUANTUM) ?
                    {{(APB_DW - QUANTUM_W){1'b0}}, tq_reg} : '0;

    assign q_eff       = (tq_reg == '0) ? QUANTUM_W'(1) : tq_reg;
    assign burst_fix   = (load.burst == '0) ? BURST_W'(1) : load.burst;
    assign scan_issue  = scan_reg < loaded_reg;
    assign arr_rd      = ab_rdata[AB_W-1:BURST_W];
    assign bur_rd      = ab_rdata[BURST_W-1:0];
    assign out_idx_inc = out_idx_reg + CW'(1);
    assign tat_calc    = comp_rdata - TICK_W'(arr_rd);
    assign load.ready  = (state_reg == S_IDLE);

    rrst_ram #(.WIDTH(AB_W), .DEPTH(MAX_PROCESSES)) u_ab_ram (
        .clk   (clk),
        .we    (ab_we),
        .waddr (loaded_reg[IW-1:0]),
        .wdata ({load.arrival, burst_fix}),
        .re    (ab_re),
        .raddr (ab_raddr),
        .rdata (ab_rdata)
    );

    rrst_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCESSES)) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (rem_re),
        .raddr (q_rdata),
        .rdata (rem_rdata)
    );

    rrst_ram #(.WIDTH(IW), .DEPTH(MAX_PROCESSES)) u_queue_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (tail_reg),
        .wdata (push_idx),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    rrst_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCESSES)) u_comp_ram (
        .clk   (clk),
        .we    (comp_we),
        .waddr (cur_reg),
        .wdata (tick_reg),
        .re    (comp_re),
        .raddr (out_idx_reg[IW-1:0]),
        .rdata (comp_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        occ_next      = occ_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        tick_next     = tick_reg;
        flag_next     = flag_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = cmp_vld_reg;
        found_next    = found_reg;
        rem_zero_next = rem_zero_reg;
        slice_next    = slice_reg;
        out_idx_next  = out_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_arr_next = best_arr_reg;
        best_idx_next = best_idx_reg;
        cur_next      = cur_reg;
        run_next      = run_reg;
        rem_val_next  = rem_val_reg;
        push_en       = 1'b0;
        push_idx      = cmp_idx_reg;
        fin_after     = finished_reg;
        occ_after     = occ_reg;
        out_load      = 1'b0;
        ab_we         = 1'b0;
        ab_re         = 1'b0;
        ab_raddr      = scan_reg[IW-1:0];
        rem_we        = 1'b0;
        rem_re        = 1'b0;
        rem_waddr     = loaded_reg[IW-1:0];
        rem_wdata     = burst_fix;
        q_re          = 1'b0;
        comp_we       = 1'b0;
        comp_re       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (load.valid)
                begin
                    if (loaded_reg < MAX_CNT)
                    begin
                        ab_we       = 1'b1;
                        rem_we      = 1'b1;
                        loaded_next = loaded_reg + CW'(1);
                    end
                    if (load.last_process)
                    begin
                        state_next    = S_ADMIT;
                        tick_next     = '0;
                        head_next     = '0;
                        tail_next     = '0;
                        occ_next      = '0;
                        finished_next = '0;
                        flag_next     = '0;
                        scan_next     = '0;
                        cmp_vld_next  = 1'b0;
                        slice_next    = 1'b0;
                    end
                end
            end
            S_ADMIT:
            begin
                cmp_vld_next = scan_issue;
                if (scan_issue)
                begin
                    ab_re        = 1'b1;
                    scan_next    = scan_reg + CW'(1);
                    cmp_idx_next = scan_reg[IW-1:0];
                end
                if (cmp_vld_reg && !flag_reg[cmp_idx_reg] &&
                    (TICK_W'(arr_rd) <= tick_reg))
                begin
                    push_en  = 1'b1;
                    push_idx = cmp_idx_reg;
                end
                if (!scan_issue && !cmp_vld_reg)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (slice_reg)
                begin
                    if (rem_zero_reg)
                    begin
                        comp_we       = 1'b1;
                        finished_next = finished_reg + CW'(1);
                        fin_after     = finished_reg + CW'(1);
                    end
                    else
                    begin
                        push_en   = 1'b1;
                        push_idx  = cur_reg;
                        occ_after = occ_reg + CW'(1);
                    end
                end
                if (fin_after == loaded_reg)
                begin
                    state_next   = S_ORD;
                    out_idx_next = '0;
                end
                else if (occ_after == '0)
                begin
                    state_next   = S_FIND;
                    scan_next    = '0;
                    cmp_vld_next = 1'b0;
                    found_next   = 1'b0;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_FIND:
            begin
                cmp_vld_next = scan_issue;
                if (scan_issue)
                begin
                    ab_re        = 1'b1;
                    scan_next    = scan_reg + CW'(1);
                    cmp_idx_next = scan_reg[IW-1:0];
                end
                if (cmp_vld_reg && !flag_reg[cmp_idx_reg] &&
                    (!found_reg || (arr_rd < best_arr_reg)))
                begin
                    best_arr_next = arr_rd;
                    best_idx_next = cmp_idx_reg;
                    found_next    = 1'b1;
                end
                if (!scan_issue && !cmp_vld_reg)
                begin
                    tick_next  = TICK_W'(best_arr_reg);
                    push_en    = 1'b1;
                    push_idx   = best_idx_reg;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                q_re       = 1'b1;
                head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + IW'(1);
                occ_next   = occ_reg - CW'(1);
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cur_next   = q_rdata;
                rem_re     = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                run_next     = (rem_rdata < q_eff) ? rem_rdata : q_eff;
                rem_val_next = rem_rdata;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                rem_we        = 1'b1;
                rem_waddr     = cur_reg;
                rem_wdata     = rem_val_reg - run_reg;
                tick_next     = tick_reg + TICK_W'(run_reg);
                rem_zero_next = (rem_val_reg == run_reg);
                slice_next    = 1'b1;
                scan_next     = '0;
                cmp_vld_next  = 1'b0;
                state_next    = S_ADMIT;
            end
            S_ORD:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    ab_re      = 1'b1;
                    ab_raddr   = out_idx_reg[IW-1:0];
                    comp_re    = 1'b1;
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                out_load = 1'b1;
                if (out_idx_inc == loaded_reg)
                begin
                    state_next    = S_IDLE;
                    loaded_next   = '0;
                    finished_next = '0;
                    occ_next      = '0;
                end
                else
                begin
                    out_idx_next = out_idx_inc;
                    state_next   = S_ORD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            tail_next           = (tail_reg == LAST_SLOT) ? '0 : tail_reg + IW'(1);
            occ_next            = occ_reg + CW'(1);
            flag_next[push_idx] = 1'b1;
        end

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tq_reg       <= QUANTUM_RESET;
            loaded_reg   <= '0;
            finished_reg <= '0;
            occ_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            tick_reg     <= '0;
            flag_reg     <= '0;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            rem_zero_reg <= 1'b0;
            slice_reg    <= 1'b0;
            out_idx_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                tq_reg <= pwdata[QUANTUM_W-1:0];
            end
            loaded_reg   <= loaded_next;
            finished_reg <= finished_next;
            occ_reg      <= occ_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            tick_reg     <= tick_next;
            flag_reg     <= flag_next;
            scan_reg     <= scan_next;
            cmp_vld_reg  <= cmp_vld_next;
            found_reg    <= found_next;
            rem_zero_reg <= rem_zero_next;
            slice_reg    <= slice_next;
            out_idx_reg  <= out_idx_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_arr_reg <= best_arr_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        run_reg      <= run_next;
        rem_val_reg  <= rem_val_next;
        if (out_load)
        begin
            pnum_reg     <= PNUM_W'(out_idx_inc);
            comp_out_reg <= comp_rdata;
            tat_out_reg  <= tat_calc;
            wait_out_reg <= tat_calc - TICK_W'(bur_rd);
            last_out_reg <= (out_idx_inc == loaded_reg);
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.process_number = pnum_reg;
    assign result.completion     = comp_out_reg;
    assign result.turnaround     = tat_out_reg;
    assign result.waiting        = wait_out_reg;
    assign result.last_result    = last_out_reg;

`ifndef SYNTHESIS
    // Every process sits in the ready queue at most once.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= loaded_reg)
        else $error("ready queue holds more entries than loaded processes");

    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg <= loaded_reg)
        else $error("more processes finished than loaded");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (occ_reg != '0))
        else $error("pop from an empty ready queue");

    // The idle-time search only runs while some process is still waiting to arrive.
    a_find_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND && !scan_issue && !cmp_vld_reg) |-> found_reg)
        else $error("idle-time search found no pending process");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OLD) |-> !out_vld_reg)
        else $error("result register overwritten before it was taken");
`endif

endmodule

[hdl/rrst_ram.sv]
module rrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
